// File: rtl/vn_pkg.sv
// Package for the 3D vector normalizer.
// Holds the fixed result width and types shared by the output interface and the top level.
package vn_pkg;

    // Width of each unit component and of the magnitude field.
    localparam int OUT_W = 16;

    typedef logic signed [OUT_W-1:0] t_unit;
    typedef logic [OUT_W-1:0]        t_mag;

endpackage

// File: rtl/vn_in_if.sv
// Input channel of the 3D vector normalizer: valid/ready plus one vector.
// Depends on nothing else in the project.
interface vn_in_if #(
    parameter int IN_WIDTH = 16
) ();
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] vec_x;
    logic signed [IN_WIDTH-1:0] vec_y;
    logic signed [IN_WIDTH-1:0] vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

// File: rtl/vn_out_if.sv
// Output channel of the 3D vector normalizer: valid/ready plus one result word.
// Depends on vn_pkg for the result types.
interface vn_out_if ();
    logic           valid;
    logic           ready;
    vn_pkg::t_unit  unit_x;
    vn_pkg::t_unit  unit_y;
    vn_pkg::t_unit  unit_z;
    vn_pkg::t_mag   magnitude;
    logic           zero_vector;

    modport source (output valid, output unit_x, output unit_y, output unit_z,
                    output magnitude, output zero_vector, input ready);
    modport sink   (input valid, input unit_x, input unit_y, input unit_z,
                    input magnitude, input zero_vector, output ready);
endinterface

// File: rtl/vector3_normalize.sv
// Pipeline: three front stages, one square root cell per root bit, one division cell per
// quotient bit, an output register.
// Throughput: one word per cycle; the whole chain advances together, stalling only while
// the output register holds a word that has not been taken.
// Reset (synchronous, active low) clears the valid bits; the data registers are not reset.
// Depends on vn_pkg, vn_in_if, vn_out_if, vn_sqrt_cell and vn_div_cell.
module vector3_normalize #(
    parameter int IN_WIDTH = 16,
    parameter int OUT_FRAC = 14
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    vn_in_if.sink    i_in,
    vn_out_if.source o_out
);

    localparam int W  = IN_WIDTH;
    localparam int QW = OUT_FRAC + 1;
    localparam int PW = 3 + 3*W;
    localparam int XW = QW + vn_pkg::OUT_W;

    logic en;

    // Front stages: absolute values, squares, sum of squares.
    logic           r_a_valid, r_b_valid, r_c_valid;
    logic [2:0]     r_a_sign, r_b_sign, r_c_sign;
    logic [W-1:0]   r_a_abs [3];
    logic [W-1:0]   r_b_abs [3];
    logic [W-1:0]   r_c_abs [3];
    logic [2*W-1:0] r_b_sq [3];
    logic [2*W-1:0] r_c_sum;

    // The chain moves whenever the output register is empty or being drained.
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sign   <= {i_in.vec_z[W-1], i_in.vec_y[W-1], i_in.vec_x[W-1]};
            r_a_abs[0] <= i_in.vec_x[W-1] ? W'(-i_in.vec_x) : W'(i_in.vec_x);
            r_a_abs[1] <= i_in.vec_y[W-1] ? W'(-i_in.vec_y) : W'(i_in.vec_y);
            r_a_abs[2] <= i_in.vec_z[W-1] ? W'(-i_in.vec_z) : W'(i_in.vec_z);
            r_b_sign   <= r_a_sign;
            r_c_sign   <= r_b_sign;
            r_c_sum    <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
            for (int k = 0; k < 3; k++) begin
                r_b_abs[k] <= r_a_abs[k];
                r_b_sq[k]  <= (2*W)'(r_a_abs[k]) * (2*W)'(r_a_abs[k]);
                r_c_abs[k] <= r_b_abs[k];
            end
        end
    end

    // Square root chain, one root bit per cell.
    logic           s_valid [W+1];
    logic [2*W-1:0] s_n     [W+1];
    logic [W+1:0]   s_rem   [W+1];
    logic [W-1:0]   s_root  [W+1];
    logic [PW-1:0]  s_side  [W+1];

    assign s_valid[0] = r_c_valid;
    assign s_n[0]     = r_c_sum;
    assign s_rem[0]   = '0;
    assign s_root[0]  = '0;
    assign s_side[0]  = {r_c_sign, r_c_abs[2], r_c_abs[1], r_c_abs[0]};

    for (genvar g = 0; g < W; g++) begin : g_sqrt
        vn_sqrt_cell #(.W(W), .PW(PW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_valid[g]),
            .i_n     (s_n[g]),
            .i_rem   (s_rem[g]),
            .i_root  (s_root[g]),
            .i_side  (s_side[g]),
            .o_valid (s_valid[g+1]),
            .o_n     (s_n[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_root  (s_root[g+1]),
            .o_side  (s_side[g+1])
        );
    end

    // Division chain, one quotient bit per cell, three lanes side by side.
    logic               d_valid [QW+1];
    logic [W-1:0]       d_len   [QW+1];
    logic [2:0]         d_sign  [QW+1];
    logic [3*(W+1)-1:0] d_rem   [QW+1];
    logic [3*QW-1:0]    d_q     [QW+1];

    assign d_valid[0] = s_valid[W];
    assign d_len[0]   = s_root[W];
    assign d_sign[0]  = s_side[W][PW-1 -: 3];
    assign d_rem[0]   = {1'b0, s_side[W][2*W +: W], 1'b0, s_side[W][W +: W],
                         1'b0, s_side[W][0 +: W]};
    assign d_q[0]     = '0;

    for (genvar g = 0; g < QW; g++) begin : g_div
        vn_div_cell #(.W(W), .QW(QW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d_valid[g]),
            .i_len   (d_len[g]),
            .i_sign  (d_sign[g]),
            .i_rem   (d_rem[g]),
            .i_q     (d_q[g]),
            .o_valid (d_valid[g+1]),
            .o_len   (d_len[g+1]),
            .o_sign  (d_sign[g+1]),
            .o_rem   (d_rem[g+1]),
            .o_q     (d_q[g+1])
        );
    end

    // Apply signs and handle the zero vector, then register the result word.
    logic            zero;
    vn_pkg::t_unit   n_unit [3];

    always_comb begin
        logic [XW-1:0] qx;
        zero = (d_len[QW] == '0);
        for (int k = 0; k < 3; k++) begin
            qx = XW'(d_q[QW][k*QW +: QW]);
            if (d_sign[QW][k]) begin
                qx = -qx;
            end
            n_unit[k] = zero ? '0 : vn_pkg::t_unit'(qx[vn_pkg::OUT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out.valid <= 1'b0;
        end else if (en) begin
            o_out.valid <= d_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out.unit_x      <= n_unit[0];
            o_out.unit_y      <= n_unit[1];
            o_out.unit_z      <= n_unit[2];
            o_out.magnitude   <= vn_pkg::OUT_W'(d_len[QW]);
            o_out.zero_vector <= zero;
        end
    end

endmodule

// File: rtl/vn_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per word.
// Standalone; chained by vector3_normalize.
module vn_sqrt_cell #(
    parameter int W  = 16,
    parameter int PW = 51
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [2*W-1:0] i_n,
    input  logic [W+1:0]   i_rem,
    input  logic [W-1:0]   i_root,
    input  logic [PW-1:0]  i_side,
    output logic           o_valid,
    output logic [2*W-1:0] o_n,
    output logic [W+1:0]   o_rem,
    output logic [W-1:0]   o_root,
    output logic [PW-1:0]  o_side
);

    logic [W+3:0] rem_s;
    logic [W+3:0] trial;
    logic         ge;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
        rem_s = {i_rem, i_n[2*W-1 -: 2]};
        trial = (W+4)'({i_root, 2'b01});
        ge    = (rem_s >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_n    <= {i_n[2*W-3:0], 2'b00};
            o_rem  <= ge ? (W+2)'(rem_s - trial) : (W+2)'(rem_s);
            o_root <= {i_root[W-2:0], ge};
            o_side <= i_side;
        end
    end

endmodule

// File: rtl/vn_div_cell.sv
// One cell of the division chain: resolves one quotient bit in three lanes.
// Standalone; chained by vector3_normalize.
module vn_div_cell #(
    parameter int W  = 16,
    parameter int QW = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [W-1:0]      i_len,
    input  logic [2:0]        i_sign,
    input  logic [3*(W+1)-1:0] i_rem,
    input  logic [3*QW-1:0]   i_q,
    output logic              o_valid,
    output logic [W-1:0]      o_len,
    output logic [2:0]        o_sign,
    output logic [3*(W+1)-1:0] o_rem,
    output logic [3*QW-1:0]   o_q
);

    logic [3*(W+1)-1:0] n_rem;
    logic [3*QW-1:0]    n_q;

    // Compare and subtract in each lane, then shift for the next bit.
    always_comb begin
        logic [W:0] r;
        logic       ge;
        n_rem = '0;
        n_q   = '0;
        for (int k = 0; k < 3; k++) begin
            r  = i_rem[k*(W+1) +: W+1];
            ge = (r >= {1'b0, i_len});
            if (ge) begin
                r = r - {1'b0, i_len};
            end
            n_rem[k*(W+1) +: W+1] = {r[W-1:0], 1'b0};
            n_q[k*QW +: QW]       = {i_q[k*QW +: QW-1], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_len  <= i_len;
            o_sign <= i_sign;
            o_rem  <= n_rem;
            o_q    <= n_q;
        end
    end

endmodule
